>>> sv/ppp_pkg.sv
// Shared types and constants for the perspective projection pipeline.
package ppp_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned PROD_W     = 2 * COORD_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned NUM_ROWS   = 3;
  localparam int unsigned NUM_COLS   = 4;
  localparam int unsigned NUM_REGS   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [QUOT_W-1:0] Q_POS_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
  localparam logic [QUOT_W-1:0] Q_NEG_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // One division lane: partial remainder, dividend bits still to shift in,
  // quotient bits so far, overflow and result sign.
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [QUOT_W-1:0] lo;
    logic [QUOT_W-1:0] quo;
    logic              ovf;
    logic              neg;
  } lane_t;

  typedef struct packed {
    coord_t image_u;
    coord_t image_v;
    logic   depth_zero;
    logic   clipped;
  } result_t;

endpackage

>>> sv/ppp_intf.sv
// Stream and configuration channel interfaces of the projection block.
interface ppp_point_if;
  logic            valid;
  logic            ready;
  ppp_pkg::coord_t point_x;
  ppp_pkg::coord_t point_y;
  ppp_pkg::coord_t point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_image_if;
  logic            valid;
  logic            ready;
  ppp_pkg::coord_t image_u;
  ppp_pkg::coord_t image_v;
  logic            depth_zero;
  logic            clipped;
  modport source (output valid, image_u, image_v, depth_zero, clipped, input ready);
  modport sink   (input valid, image_u, image_v, depth_zero, clipped, output ready);
endinterface

interface ppp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ppp_pkg::CFG_IDX_W-1:0]      index;
  logic [ppp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/project_point_perspective.sv
// Perspective projection of a Q-format 3D point through a 3x4 camera matrix.
//
// Channels: point_i carries one point (x, y, z) per transfer; image_o returns
// one result (u, v, depth_zero, clipped) per point, in order. cfg_i writes
// the six 64-bit matrix registers (two signed entries each, entry c in the
// high half); ready is always high and indexes past the list are dropped.
// Write the matrix only while no point is in flight.
// Throughput: one point per cycle while the skid entry is empty; the rate is set by the pipeline itself:
// one multiply stage, two adder stages, a sign stage, an overflow compare
// and one restoring division step per quotient bit (32 stages, two lanes
// sharing the divisor).
// Stall: the whole pipeline advances together. An output register plus one
// skid entry sit behind the last stage, so a stalled receiver blocks input
// only once the skid entry fills; nothing is dropped or repeated.
// Reset: clears all valid bits, including those of the output and skid
// entries, and the matrix registers to zero.
module project_point_perspective #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppp_cfg_if.sink           cfg_i,
  ppp_point_if.sink         point_i,
  ppp_image_if.source       image_o
);

  localparam int unsigned SUM_W  = ppp_pkg::SUM_W;
  localparam int unsigned QUOT_W = ppp_pkg::QUOT_W;
  localparam int unsigned NUM_W  = SUM_W + FRAC_BITS;
  localparam int unsigned DIV_N  = QUOT_W;
  // s1 products, s2 pairs, s3 sums, s4 magnitudes, s5 overflow, then divider
  localparam int unsigned DEPTH  = 5 + DIV_N;

  // ---------------- configuration ----------------
  logic [ppp_pkg::CFG_DATA_W-1:0] m_q [ppp_pkg::NUM_REGS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppp_pkg::NUM_REGS; i++) m_q[i] <= '0;
    end else if (cfg_i.valid && cfg_i.ready &&
                 (cfg_i.index < ppp_pkg::CFG_IDX_W'(ppp_pkg::NUM_REGS))) begin
      m_q[cfg_i.index] <= cfg_i.data;
    end
  end

  logic signed [ppp_pkg::COORD_W-1:0] ent [ppp_pkg::NUM_ROWS][ppp_pkg::NUM_COLS];

  for (genvar r = 0; r < ppp_pkg::NUM_ROWS; r++) begin : g_ent_row
    for (genvar c = 0; c < ppp_pkg::NUM_COLS; c++) begin : g_ent_col
      if (c % 2 == 0) begin : g_hi
        assign ent[r][c] = m_q[r * 2 + c / 2][63:32];
      end else begin : g_lo
        assign ent[r][c] = m_q[r * 2 + c / 2][31:0];
      end
    end
  end

  // ---------------- flow control ----------------
  logic             pipe_en;
  logic             in_fire;
  logic [DEPTH-1:0] vld_q;
  logic             out_valid_q;
  logic             skid_valid_q;
  ppp_pkg::result_t out_q, skid_q, fin;

  assign pipe_en       = !skid_valid_q;
  assign point_i.ready = pipe_en;
  assign in_fire       = point_i.valid && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_fire};
    end
  end

  // ---------------- s1: products ----------------
  ppp_pkg::coord_t pt [3];
  logic signed [ppp_pkg::PROD_W-1:0] prod_d [ppp_pkg::NUM_ROWS][ppp_pkg::NUM_COLS];
  logic signed [ppp_pkg::PROD_W-1:0] prod_q [ppp_pkg::NUM_ROWS][ppp_pkg::NUM_COLS];

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  always_comb begin
    for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = ent[r][c] * pt[c];
      end
      // the homogeneous 1.0 term needs only a shift
      prod_d[r][3] = ppp_pkg::PROD_W'(ent[r][3]) <<< FRAC_BITS;
    end
  end

  // ---------------- s2 / s3: row sums ----------------
  logic signed [ppp_pkg::PAIR_W-1:0] pair_d [ppp_pkg::NUM_ROWS][2];
  logic signed [ppp_pkg::PAIR_W-1:0] pair_q [ppp_pkg::NUM_ROWS][2];
  logic signed [SUM_W-1:0]           sum_d  [ppp_pkg::NUM_ROWS];
  logic signed [SUM_W-1:0]           sum_q  [ppp_pkg::NUM_ROWS];

  always_comb begin
    for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
      pair_d[r][0] = ppp_pkg::PAIR_W'(prod_q[r][0]) + ppp_pkg::PAIR_W'(prod_q[r][1]);
      pair_d[r][1] = ppp_pkg::PAIR_W'(prod_q[r][2]) + ppp_pkg::PAIR_W'(prod_q[r][3]);
      sum_d[r]     = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
    end
  end

  // ---------------- s4: magnitudes and signs ----------------
  logic [SUM_W-1:0] mag_d [ppp_pkg::NUM_ROWS];
  logic [SUM_W-1:0] mag_q [ppp_pkg::NUM_ROWS];
  logic             neg_u_d, neg_v_d, zero_d;
  logic             neg_u_q, neg_v_q, zero_q;

  always_comb begin
    for (int r = 0; r < ppp_pkg::NUM_ROWS; r++) begin
      mag_d[r] = sum_q[r][SUM_W-1] ? SUM_W'(-sum_q[r]) : SUM_W'(sum_q[r]);
    end
    neg_u_d = sum_q[0][SUM_W-1] ^ sum_q[2][SUM_W-1];
    neg_v_d = sum_q[1][SUM_W-1] ^ sum_q[2][SUM_W-1];
    zero_d  = (sum_q[2] == '0);
  end

  // ---------------- s5: overflow check, divider setup ----------------
  ppp_pkg::lane_t   lane_q [DIV_N+1][2];
  logic [SUM_W-1:0] den_q  [DIV_N];
  logic             zro_q  [DIV_N+1];
  ppp_pkg::lane_t   lane0_d [2];

  always_comb begin
    logic [NUM_W-1:0]    num;
    logic [NUM_W-33:0]   top;
    logic                neg;
    for (int l = 0; l < 2; l++) begin
      num = {mag_q[l], {FRAC_BITS{1'b0}}};
      top = num[NUM_W-1:QUOT_W];
      neg = (l == 0) ? neg_u_q : neg_v_q;
      // quotient needs more than 32 bits when the upper dividend reaches the divisor
      lane0_d[l].ovf = (SUM_W'(top) >= mag_q[2]);
      lane0_d[l].rem = lane0_d[l].ovf ? '0 : SUM_W'(top);
      lane0_d[l].lo  = num[QUOT_W-1:0];
      lane0_d[l].quo = '0;
      lane0_d[l].neg = neg;
    end
  end

  // ---------------- s6..: restoring division, one bit per stage ----------------
  ppp_pkg::lane_t lane_d [DIV_N+1][2];

  assign lane_d[0][0] = lane0_d[0];
  assign lane_d[0][1] = lane0_d[1];

  for (genvar k = 1; k <= DIV_N; k++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SUM_W:0] trial;
      logic           ge;
      logic [SUM_W:0] diff;
      assign trial = {lane_q[k-1][l].rem, lane_q[k-1][l].lo[QUOT_W-1]};
      assign ge    = (trial >= {1'b0, den_q[k-1]});
      assign diff  = trial - {1'b0, den_q[k-1]};
      assign lane_d[k][l].rem = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      assign lane_d[k][l].lo  = {lane_q[k-1][l].lo[QUOT_W-2:0], 1'b0};
      assign lane_d[k][l].quo = {lane_q[k-1][l].quo[QUOT_W-2:0], ge};
      assign lane_d[k][l].ovf = lane_q[k-1][l].ovf;
      assign lane_d[k][l].neg = lane_q[k-1][l].neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q  <= prod_d;
      pair_q  <= pair_d;
      sum_q   <= sum_d;
      mag_q   <= mag_d;
      neg_u_q <= neg_u_d;
      neg_v_q <= neg_v_d;
      zero_q  <= zero_d;
      den_q[0] <= mag_q[2];
      zro_q[0] <= zero_q;
      for (int k = 1; k < DIV_N; k++) begin
        den_q[k] <= den_q[k-1];
      end
      for (int k = 1; k <= DIV_N; k++) begin
        zro_q[k] <= zro_q[k-1];
      end
      for (int k = 0; k <= DIV_N; k++) begin
        lane_q[k] <= lane_d[k];
      end
    end
  end

  // ---------------- sign, saturation, zero depth ----------------
  function automatic logic [QUOT_W:0] lane_result(input ppp_pkg::lane_t ln);
    logic [QUOT_W-1:0] val;
    logic              clip;
    clip = 1'b0;
    if (ln.neg) begin
      if (ln.ovf || (ln.quo > ppp_pkg::Q_NEG_MIN)) begin
        val  = ppp_pkg::Q_NEG_MIN;
        clip = 1'b1;
      end else begin
        val = QUOT_W'(-ln.quo);
      end
    end else begin
      if (ln.ovf || (ln.quo > ppp_pkg::Q_POS_MAX)) begin
        val  = ppp_pkg::Q_POS_MAX;
        clip = 1'b1;
      end else begin
        val = ln.quo;
      end
    end
    return {clip, val};
  endfunction

  logic [QUOT_W:0] res_u, res_v;

  assign res_u = lane_result(lane_q[DIV_N][0]);
  assign res_v = lane_result(lane_q[DIV_N][1]);

  always_comb begin
    if (zro_q[DIV_N]) begin
      fin.image_u    = '0;
      fin.image_v    = '0;
      fin.depth_zero = 1'b1;
      fin.clipped    = 1'b0;
    end else begin
      fin.image_u    = res_u[QUOT_W-1:0];
      fin.image_v    = res_v[QUOT_W-1:0];
      fin.depth_zero = 1'b0;
      fin.clipped    = res_u[QUOT_W] | res_v[QUOT_W];
    end
  end

  // ---------------- output register and skid entry ----------------
  logic out_free;
  logic produced;

  assign out_free = !out_valid_q || image_o.ready;
  assign produced = pipe_en && vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produced;
      end
    end else if (produced) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (produced) begin
        out_q <= fin;
      end
    end else if (produced) begin
      skid_q <= fin;
    end
  end

  assign image_o.valid      = out_valid_q;
  assign image_o.image_u    = out_q.image_u;
  assign image_o.image_v    = out_q.image_v;
  assign image_o.depth_zero = out_q.depth_zero;
  assign image_o.clipped    = out_q.clipped;

endmodule

>>> sv/ppp_checker.sv
// Port-level checks for the perspective projection block, bound to the top.
module ppp_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_ready_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [31:0]            out_u_i,
  input logic [31:0]            out_v_i,
  input logic                   out_zero_i,
  input logic                   out_clip_i
);

  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("cfg channel not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // input stalls only when a result is stuck at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && $past(out_valid_i))
    else $error("input stalled without a waiting result");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_zero_i |-> out_u_i == '0 && out_v_i == '0 && !out_clip_i)
    else $error("zero depth result not cleared");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_clip_i |->
      out_u_i == SatMax || out_u_i == SatMin || out_v_i == SatMax || out_v_i == SatMin)
    else $error("clip flag without saturated coordinate");

endmodule

bind project_point_perspective ppp_checker u_ppp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_i (cfg_i.ready),
  .in_ready_i  (point_i.ready),
  .out_valid_i (image_o.valid),
  .out_ready_i (image_o.ready),
  .out_u_i     (image_o.image_u),
  .out_v_i     (image_o.image_v),
  .out_zero_i  (image_o.depth_zero),
  .out_clip_i  (image_o.clipped)
);
